[sv/h264fu_pkg.sv]
`timescale 1ns / 1ps

package h264fu_pkg;

  localparam int MAX_PAYLOAD = 1400;
  localparam int LEN_W       = 20;
  localparam int FILL_W      = 11;
  localparam int STEP_W      = 17;

  localparam logic [LEN_W-1:0]  MAX_LEN  = LEN_W'(MAX_PAYLOAD);
  localparam logic [FILL_W:0]   MAX_FILL = (FILL_W+1)'(MAX_PAYLOAD);
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(3600);

  localparam logic [4:0] NAL_TYPE_SPS = 5'd7;
  localparam logic [4:0] NAL_TYPE_PPS = 5'd8;
  localparam logic [4:0] NAL_TYPE_FUA = 5'd28;
  localparam logic [7:0] NRI_MASK     = 8'h60;
  localparam logic [7:0] TYPE_MASK    = 8'h1F;
  localparam logic [7:0] FU_S_BIT     = 8'h80;
  localparam logic [7:0] FU_E_BIT     = 8'h40;

  typedef struct packed {
    logic [7:0]       nal_byte;
    logic             unit_first;
    logic [LEN_W-1:0] unit_length;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        packet_start;
    logic        packet_end;
    logic [15:0] sequence_number;
    logic [31:0] rtp_timestamp;
  } out_word_t;

  // up to three words caused by one input word, front word in slot 0
  typedef struct packed {
    logic [1:0]          cnt;
    out_word_t [2:0]     w;
  } burst_t;

endpackage

[sv/h264fu_core.sv]
`timescale 1ns / 1ps

module h264fu_core import h264fu_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  in_word_t          in_word,
  input  logic              cfg_we,
  input  logic [STEP_W-1:0] cfg_step,
  output burst_t            burst
);

  logic [STEP_W-1:0] step_r;
  logic [15:0]       seq_r, seq_nxt;
  logic [31:0]       ts_r, ts_nxt;
  logic [7:0]        hdr_r, hdr_nxt;
  logic [LEN_W-1:0]  left_r, left_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              frag_r, frag_nxt;
  logic              ff_r, ff_nxt;

  logic [LEN_W-1:0]  len0;
  logic [LEN_W-1:0]  left_dec;
  logic [7:0]        fuh;
  logic [4:0]        cur_type;
  logic              seg_end;
  logic              is_param;

  function automatic out_word_t mk(logic [7:0] b, logic s, logic e,
                                   logic [15:0] sq, logic [31:0] t);
    out_word_t o;
    o.payload_byte    = b;
    o.packet_start    = s;
    o.packet_end      = e;
    o.sequence_number = sq;
    o.rtp_timestamp   = t;
    return o;
  endfunction

  always_comb begin
    seq_nxt  = seq_r;
    ts_nxt   = ts_r;
    hdr_nxt  = hdr_r;
    left_nxt = left_r;
    fill_nxt = fill_r;
    frag_nxt = frag_r;
    ff_nxt   = ff_r;
    burst    = '0;

    len0     = (in_word.unit_length == '0) ? LEN_W'(1) : in_word.unit_length;
    left_dec = left_r - LEN_W'(1);
    cur_type = in_word.unit_first ? in_word.nal_byte[4:0] : hdr_r[4:0];
    is_param = (cur_type == NAL_TYPE_SPS) || (cur_type == NAL_TYPE_PPS);
    seg_end  = (({1'b0, fill_r} + (FILL_W+1)'(1)) >= MAX_FILL) || (left_r == LEN_W'(1));
    fuh      = (hdr_r & TYPE_MASK) | (ff_r ? FU_S_BIT :
               ((left_r <= MAX_LEN) ? FU_E_BIT : 8'h00));

    if (in_word.unit_first) begin
      hdr_nxt  = in_word.nal_byte;
      fill_nxt = '0;
      left_nxt = len0 - LEN_W'(1);
      if (len0 <= MAX_LEN) begin
        frag_nxt   = 1'b0;
        ff_nxt     = 1'b0;
        burst.cnt  = 2'd1;
        burst.w[0] = mk(in_word.nal_byte, 1'b1, len0 == LEN_W'(1), seq_r, ts_r);
        if (len0 == LEN_W'(1)) begin
          seq_nxt = seq_r + 16'd1;
          if (!is_param) ts_nxt = ts_r + 32'(step_r);
        end
      end else begin
        frag_nxt = 1'b1;
        ff_nxt   = 1'b1;
      end
    end else if (left_r != '0) begin
      left_nxt = left_dec;
      if (!frag_r) begin
        burst.cnt  = 2'd1;
        burst.w[0] = mk(in_word.nal_byte, 1'b0, left_r == LEN_W'(1), seq_r, ts_r);
        if (left_r == LEN_W'(1)) begin
          seq_nxt = seq_r + 16'd1;
          if (!is_param) ts_nxt = ts_r + 32'(step_r);
        end
      end else begin
        if (fill_r == '0) begin
          burst.cnt  = 2'd3;
          burst.w[0] = mk((hdr_r & NRI_MASK) | {3'b000, NAL_TYPE_FUA}, 1'b1, 1'b0,
                          seq_r, ts_r);
          burst.w[1] = mk(fuh, 1'b0, 1'b0, seq_r, ts_r);
          burst.w[2] = mk(in_word.nal_byte, 1'b0, seg_end, seq_r, ts_r);
        end else begin
          burst.cnt  = 2'd1;
          burst.w[0] = mk(in_word.nal_byte, 1'b0, seg_end, seq_r, ts_r);
        end
        fill_nxt = fill_r + FILL_W'(1);
        if (seg_end) begin
          seq_nxt  = seq_r + 16'd1;
          fill_nxt = '0;
          ff_nxt   = 1'b0;
        end
        // unit done after its last fragment byte
        if (left_r == LEN_W'(1)) begin
          frag_nxt = 1'b0;
          ts_nxt   = ts_r + 32'(step_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_RESET;
      seq_r  <= '0;
      ts_r   <= '0;
      hdr_r  <= '0;
      left_r <= '0;
      fill_r <= '0;
      frag_r <= 1'b0;
      ff_r   <= 1'b0;
    end else begin
      if (cfg_we) step_r <= cfg_step;
      if (load) begin
        seq_r  <= seq_nxt;
        ts_r   <= ts_nxt;
        hdr_r  <= hdr_nxt;
        left_r <= left_nxt;
        fill_r <= fill_nxt;
        frag_r <= frag_nxt;
        ff_r   <= ff_nxt;
      end
    end
  end

endmodule

[sv/h264fu_obuf.sv]
`timescale 1ns / 1ps

module h264fu_obuf import h264fu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  burst_t    burst,
  output logic      can_load,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  out_word_t [2:0] slot_r;
  logic [1:0]      cnt_r;
  logic            pop;

  assign out_valid = (cnt_r != 2'd0);
  assign out_word  = slot_r[0];
  assign pop       = out_valid && !out_stall;
  // take a new burst when empty or when the last word leaves this cycle
  assign can_load  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (load) begin
      cnt_r <= burst.cnt;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot_r <= burst.w;
    end else if (pop) begin
      slot_r[0] <= slot_r[1];
      slot_r[1] <= slot_r[2];
    end
  end

endmodule

[sv/h264_rtp_fu_a_packetizer_unit.sv]
`timescale 1ns / 1ps

// h264 rtp fu-a packetizer
// in channel: one nal unit byte per word (in_valid / in_stall); unit_first and
// unit_length mark the header byte of each unit.
// out channel: one rtp payload byte per word (out_valid / out_stall) with
// packet_start / packet_end flags, sequence number and timestamp.
// cfg channel: cfg_valid / cfg_ready writes timestamp_step; cfg_ready is
// always high, write only while the block is idle.
// a result word is registered and shows in the cycle after its input is taken.
// throughput: one input word per cycle while out_stall is low for pass-through
// and fragment body bytes; the first byte of every fu-a fragment yields three
// output words (fu indicator, fu header, data), so in_stall stays high until
// the three-slot output buffer, draining one word a cycle, is down to its last word.
// header bytes of fragmented units give no output word.
// when the receiver stalls the front word holds and in_stall rises as soon as
// the buffer cannot take a full new burst.
// reset: synchronous active-low; clears counters, unit state and the buffer,
// timestamp_step returns to 3600.
module h264_rtp_fu_a_packetizer_unit import h264fu_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_word_t          in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output out_word_t         out_word,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [STEP_W-1:0] cfg_data
);

  burst_t burst;
  logic   can_load;
  logic   load;

  assign in_stall  = !can_load;
  assign load      = in_valid && can_load;
  assign cfg_ready = 1'b1;

  h264fu_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (load),
    .in_word  (in_word),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_step (cfg_data),
    .burst    (burst)
  );

  h264fu_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .burst     (burst),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

[sv/h264fu_checker.sv]
`timescale 1ns / 1ps

module h264fu_checker import h264fu_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_word))
    else $error("out word changed while stalled");

  // an empty output side always takes a word
  a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // sequence number and timestamp move only after a packet end
  a_pkt_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_word.packet_end |=>
      !out_valid ||
      ((out_word.sequence_number == $past(out_word.sequence_number)) &&
       (out_word.rtp_timestamp == $past(out_word.rtp_timestamp))))
    else $error("packet fields changed inside a packet");

endmodule

bind h264_rtp_fu_a_packetizer_unit h264fu_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
